### rtl/radix_digit_string_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit string converter
// Shared shorthand for concurrent checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_STRING_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_STRING_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RDSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RDSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg
// Constants, types and helper functions of the radix digit string converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsc_pkg;

  // Sizing
  localparam int VALUE_BITS = 64;
  localparam int MAX_RADIX  = 16;
  localparam int IN_W       = 64;
  localparam int DIG_W      = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int RADIX_W    = 5;
  localparam int NUM_DIGITS = VALUE_BITS;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CONV_LAST  = 2 * VALUE_BITS - 2;
  localparam int CONV_W     = $clog2(CONV_LAST + 1);
  localparam int CHAR_W     = 8;
  localparam int ALPHA_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register reset values
  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHA_HI_RST = 64'h6665646362613938;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX    = 2'd0,
    CFG_ALPHA_LO = 2'd1,
    CFG_ALPHA_HI = 2'd2
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Map a digit onto its alphabet byte
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIG_W-1:0] d,
                                                  input logic [ALPHA_W-1:0] lo,
                                                  input logic [ALPHA_W-1:0] hi);
    logic [3:0]         dd;
    logic [ALPHA_W-1:0] word;
    dd   = 4'(d);
    word = dd[3] ? hi : lo;
    return word[{dd[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

### rtl/rdsc_in_if.sv
// ----------------------------------------------------------------------------
// rdsc_in_if
// Valid/ready channel carrying one value to convert.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rdsc_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/rdsc_out_if.sv
// ----------------------------------------------------------------------------
// rdsc_out_if
// Valid/ready channel carrying one output character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdsc_pkg::CHAR_W-1:0] digit_char;
  logic                        last_char;
  logic                        bad_radix;

  modport source (output valid, output digit_char, output last_char, output bad_radix,
                  input ready);
  modport sink   (input valid, input digit_char, input last_char, input bad_radix,
                  output ready);
endinterface

`default_nettype wire

### rtl/radix_digit_string_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter
// Converts an unsigned value into a string of alphabet characters in a
// configurable radix, most significant digit first.
// ----------------------------------------------------------------------------
// One value is handled at a time. The value is shifted in one bit per cycle,
// MSB first, into a row of 64 digit cells; each cell doubles its digit, adds
// the carry from the cell below and reduces modulo the radix, and hands its
// carry to the next cell through a register, so the bit wavefront ripples up
// the row. The row is then shifted out from the top, one digit per cycle
// while the output is not stalled, with leading zeros dropped. A radix below
// two gives a single error character in the cycle after the transfer.
// Radix values above 16 act as 16.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_string_converter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  rdsc_in_if.sink                                 in_ch,
  rdsc_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [rdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rdsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int TOP = rdsc_pkg::NUM_DIGITS - 1;

  // Configuration registers
  logic [rdsc_pkg::RADIX_W-1:0] radix_r;
  logic [rdsc_pkg::ALPHA_W-1:0] alpha_lo_r;
  logic [rdsc_pkg::ALPHA_W-1:0] alpha_hi_r;

  // Control
  rdsc_pkg::state_t              st_r, st_nxt;
  logic [rdsc_pkg::CONV_W-1:0]   conv_cnt_r, conv_cnt_nxt;
  logic [rdsc_pkg::IDX_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic                          started_r, started_nxt;

  // Value shift register and digit cells
  logic [rdsc_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic [rdsc_pkg::DIG_W-1:0]      dig_r   [rdsc_pkg::NUM_DIGITS];
  logic [rdsc_pkg::DIG_W-1:0]      dig_nxt [rdsc_pkg::NUM_DIGITS];
  logic [rdsc_pkg::NUM_DIGITS-1:0] car_r, car_nxt;
  logic [rdsc_pkg::NUM_DIGITS-1:0] ven_r, ven_nxt;
  logic [rdsc_pkg::NUM_DIGITS-1:0] cin_vec, en_vec;

  // Output register
  logic                        out_vld_r, out_vld_nxt;
  logic [rdsc_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_bad_r, out_bad_nxt;

  logic [rdsc_pkg::RADIX_W-1:0] radix_eff;
  logic                         bad_radix;
  logic                         out_free;
  logic                         in_ready;
  logic                         in_xfer;
  logic                         feed_en;
  logic                         emit_last;
  logic                         emit_show;
  logic                         emit_adv;
  logic [rdsc_pkg::RADIX_W-1:0] dbl;

  // Effective radix, clamped to the alphabet size
  assign radix_eff = (radix_r > rdsc_pkg::RADIX_W'(rdsc_pkg::MAX_RADIX)) ?
                     rdsc_pkg::RADIX_W'(rdsc_pkg::MAX_RADIX) : radix_r;
  assign bad_radix = radix_eff < rdsc_pkg::RADIX_W'(2);

  // Handshake
  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ready = (st_r == rdsc_pkg::ST_IDLE) && out_free;
  assign in_xfer  = in_ch.valid && in_ready;

  // Bit feed into cell 0 while the conversion counter is below VALUE_BITS
  assign feed_en = (st_r == rdsc_pkg::ST_CONV) &&
                   (conv_cnt_r < rdsc_pkg::CONV_W'(rdsc_pkg::VALUE_BITS));
  assign cin_vec = {car_r[rdsc_pkg::NUM_DIGITS-2:0], val_r[rdsc_pkg::VALUE_BITS-1]};
  assign en_vec  = {ven_r[rdsc_pkg::NUM_DIGITS-2:0], feed_en};

  // Emission: drop leading zeros, always show the lowest digit
  assign emit_last = emit_cnt_r == rdsc_pkg::IDX_W'(TOP);
  assign emit_show = started_r || (dig_r[TOP] != '0) || emit_last;
  assign emit_adv  = (st_r == rdsc_pkg::ST_EMIT) && out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= rdsc_pkg::RADIX_RST;
      alpha_lo_r <= rdsc_pkg::ALPHA_LO_RST;
      alpha_hi_r <= rdsc_pkg::ALPHA_HI_RST;
    end else if (cfg_we) begin
      case (rdsc_pkg::cfg_idx_t'(cfg_index))
        rdsc_pkg::CFG_RADIX:    radix_r    <= cfg_wdata[rdsc_pkg::RADIX_W-1:0];
        rdsc_pkg::CFG_ALPHA_LO: alpha_lo_r <= cfg_wdata[rdsc_pkg::ALPHA_W-1:0];
        rdsc_pkg::CFG_ALPHA_HI: alpha_hi_r <= cfg_wdata[rdsc_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller and output register next state
  always_comb begin
    st_nxt       = st_r;
    conv_cnt_nxt = conv_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    started_nxt  = started_r;
    val_nxt      = val_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    case (st_r)
      rdsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (bad_radix) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = '0;
            out_last_nxt = 1'b1;
            out_bad_nxt  = 1'b1;
          end else begin
            st_nxt       = rdsc_pkg::ST_CONV;
            conv_cnt_nxt = '0;
            val_nxt      = in_ch.value[rdsc_pkg::VALUE_BITS-1:0];
          end
        end
      end
      rdsc_pkg::ST_CONV: begin
        conv_cnt_nxt = conv_cnt_r + 1'b1;
        val_nxt      = {val_r[rdsc_pkg::VALUE_BITS-2:0], 1'b0};
        if (conv_cnt_r == rdsc_pkg::CONV_W'(rdsc_pkg::CONV_LAST)) begin
          st_nxt       = rdsc_pkg::ST_EMIT;
          emit_cnt_nxt = '0;
          started_nxt  = 1'b0;
        end
      end
      rdsc_pkg::ST_EMIT: begin
        if (emit_adv) begin
          emit_cnt_nxt = emit_cnt_r + 1'b1;
          if (emit_show) begin
            started_nxt  = 1'b1;
            out_vld_nxt  = 1'b1;
            out_char_nxt = rdsc_pkg::symbol_of(dig_r[TOP], alpha_lo_r, alpha_hi_r);
            out_last_nxt = emit_last;
            out_bad_nxt  = 1'b0;
          end
          if (emit_last) begin
            st_nxt = rdsc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = rdsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Digit cells: double-and-add with modular reduction, or shift toward the top
  always_comb begin
    dbl = '0;
    for (int j = 0; j < rdsc_pkg::NUM_DIGITS; j++) begin
      dig_nxt[j] = dig_r[j];
      car_nxt[j] = 1'b0;
      ven_nxt[j] = en_vec[j];
      if (in_xfer) begin
        dig_nxt[j] = '0;
      end else if (emit_adv) begin
        dig_nxt[j] = (j == 0) ? '0 : dig_r[(j == 0) ? 0 : j - 1];
      end else if (en_vec[j]) begin
        dbl = rdsc_pkg::RADIX_W'({dig_r[j], cin_vec[j]});
        if (dbl >= radix_eff) begin
          dig_nxt[j] = rdsc_pkg::DIG_W'(dbl - radix_eff);
          car_nxt[j] = 1'b1;
        end else begin
          dig_nxt[j] = rdsc_pkg::DIG_W'(dbl);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= rdsc_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      ven_r     <= '0;
      car_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      ven_r     <= ven_nxt;
      car_r     <= car_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    conv_cnt_r <= conv_cnt_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    started_r  <= started_nxt;
    val_r      <= val_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    for (int j = 0; j < rdsc_pkg::NUM_DIGITS; j++) begin
      dig_r[j] <= dig_nxt[j];
    end
  end

  // Port drive
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_vld_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last_char  = out_last_r;
  assign out_ch.bad_radix  = out_bad_r;

endmodule

`default_nettype wire

### rtl/rdsc_checker.sv
// ----------------------------------------------------------------------------
// rdsc_checker
// Port-level checks of the radix digit string converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_string_converter_assert.svh"

module rdsc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rdsc_pkg::CHAR_W-1:0] out_digit_char,
  input wire logic                        out_last_char,
  input wire logic                        out_bad_radix
);

  // A stalled character holds until its transfer
  `RDSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digit_char) && $stable(out_last_char) && $stable(out_bad_radix), "stalled output changed")

  // An error result is a lone, closing, zero character
  `RDSC_ASSERT_NOW(a_bad_form, clk, rst_n, out_valid && out_bad_radix, out_last_char && (out_digit_char == '0), "malformed error result")

  // After a transfer the block is either converting or showing the error
  `RDSC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready || out_valid, "input taken while a value is in flight")

  // An error result appears only right after an input transfer
  `RDSC_ASSERT_NOW(a_bad_src, clk, rst_n, $rose(out_valid) && out_bad_radix, $past(in_valid && in_ready), "error result without input")

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_digit_char (out_ch.digit_char),
  .out_last_char  (out_ch.last_char),
  .out_bad_radix  (out_ch.bad_radix)
);

`default_nettype wire

### tb/tb_radix_digit_string_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_digit_string_converter
// Self-checking bench for the radix digit string converter. Values are pushed
// through the input channel under several radix and alphabet settings, and a
// scoreboard predicts the character string of each accepted value and
// compares every output transfer with it. Both channels idle at random. The
// output side also holds off once for a long stretch so the input backs up.
// ----------------------------------------------------------------------------

module tb_radix_digit_string_converter;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int END_CYCLES   = 200;
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 88;
  localparam int CALM_ITEMS   = 20;
  localparam int REPORT_MAX   = 100;

  // Register index with no register behind it
  localparam logic [rdsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, expected characters in order
  // --------------------------------------------------------------------------
  class digit_text_scoreboard;
    typedef struct packed {
      logic [rdsc_pkg::CHAR_W-1:0] digit_char;
      logic                        last_char;
      logic                        bad_radix;
    } char_t;

    logic [rdsc_pkg::RADIX_W-1:0] radix;
    logic [rdsc_pkg::ALPHA_W-1:0] alpha_lo;
    logic [rdsc_pkg::ALPHA_W-1:0] alpha_hi;
    char_t                        expected_chars[$];
    bit [31:0]                    radix_used;
    int unsigned                  errors;
    int unsigned                  values_in;
    int unsigned                  chars_out;
    int unsigned                  bad_out;
    int                           longest;

    function new();
      radix      = rdsc_pkg::RADIX_RST;
      alpha_lo   = rdsc_pkg::ALPHA_LO_RST;
      alpha_hi   = rdsc_pkg::ALPHA_HI_RST;
      radix_used = '0;
      errors     = 0;
      values_in  = 0;
      chars_out  = 0;
      bad_out    = 0;
      longest    = 0;
    endfunction

    function void write_reg(logic [rdsc_pkg::CFG_IDX_W-1:0] index,
                            logic [rdsc_pkg::CFG_DATA_W-1:0] data);
      case (index)
        rdsc_pkg::CFG_RADIX:    radix    = data[rdsc_pkg::RADIX_W-1:0];
        rdsc_pkg::CFG_ALPHA_LO: alpha_lo = data;
        rdsc_pkg::CFG_ALPHA_HI: alpha_hi = data;
        default: ;
      endcase
    endfunction

    // Alphabet byte of one digit
    function logic [rdsc_pkg::CHAR_W-1:0] glyph(logic [3:0] d);
      logic [rdsc_pkg::ALPHA_W-1:0] word;
      word = d[3] ? alpha_hi : alpha_lo;
      return rdsc_pkg::CHAR_W'(word >> (8 * d[2:0]));
    endfunction

    // Expand an accepted value into its characters, most significant first
    function void add_value(logic [rdsc_pkg::IN_W-1:0] value);
      logic [rdsc_pkg::VALUE_BITS-1:0] quot;
      logic [3:0]                      digits[0:rdsc_pkg::NUM_DIGITS-1];
      int unsigned                     base;
      int                              n;
      int                              k;
      char_t                           c;
      values_in++;
      radix_used[radix] = 1'b1;
      quot = value[rdsc_pkg::VALUE_BITS-1:0];
      base = (radix > rdsc_pkg::MAX_RADIX) ? rdsc_pkg::MAX_RADIX : radix;
      if (base < 2) begin
        c.digit_char = '0;
        c.last_char  = 1'b1;
        c.bad_radix  = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      n = 0;
      if (quot == 0) begin
        digits[0] = 4'd0;
        n = 1;
      end
      // remainders come out least significant first
      while (quot != 0 && n < rdsc_pkg::NUM_DIGITS) begin
        digits[n] = 4'(quot % base);
        quot      = quot / base;
        n++;
      end
      if (n > longest) longest = n;
      for (k = n - 1; k >= 0; k--) begin
        c.digit_char = glyph(digits[k]);
        c.last_char  = (k == 0);
        c.bad_radix  = 1'b0;
        expected_chars.push_back(c);
      end
    endfunction

    function void mismatch(string field, logic [rdsc_pkg::CHAR_W-1:0] exp_v,
                           logic [rdsc_pkg::CHAR_W-1:0] act_v);
      errors++;
      if (errors <= REPORT_MAX)
        $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
    endfunction

    function void check_char(logic [rdsc_pkg::CHAR_W-1:0] digit_char, logic last_char,
                             logic bad_radix);
      char_t exp_c;
      chars_out++;
      if (bad_radix === 1'b1) bad_out++;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $error("unexpected character: digit_char %0h, last_char %0b, bad_radix %0b",
                 digit_char, last_char, bad_radix);
        return;
      end
      exp_c = expected_chars.pop_front();
      if (digit_char !== exp_c.digit_char)
        mismatch("digit_char", exp_c.digit_char, digit_char);
      if (last_char !== exp_c.last_char)
        mismatch("last_char", exp_c.last_char, last_char);
      if (bad_radix !== exp_c.bad_radix)
        mismatch("bad_radix", exp_c.bad_radix, bad_radix);
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, channels, block
  // --------------------------------------------------------------------------
  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rdsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rdsc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              calm = 1'b0;
  bit                              hold_req = 1'b0;
  int unsigned                     quiet = 0;

  rdsc_in_if  in_ch ();
  rdsc_out_if out_ch ();

  digit_text_scoreboard sb = new();

  radix_digit_string_converter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one value, maybe after an idle gap, and wait for its transfer
  task automatic send_value(input logic [rdsc_pkg::IN_W-1:0] value);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.add_value(value);
  endtask

  task automatic write_reg(input logic [rdsc_pkg::CFG_IDX_W-1:0] index,
                           input logic [rdsc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  // Full register set; optionally also pokes the unmapped index
  task automatic set_config(input logic [rdsc_pkg::CFG_DATA_W-1:0] radix_data,
                            input logic [rdsc_pkg::CFG_DATA_W-1:0] lo,
                            input logic [rdsc_pkg::CFG_DATA_W-1:0] hi,
                            input bit poke_unused);
    write_reg(rdsc_pkg::CFG_RADIX, radix_data);
    write_reg(rdsc_pkg::CFG_ALPHA_LO, lo);
    write_reg(rdsc_pkg::CFG_ALPHA_HI, hi);
    if (poke_unused) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait for every expected character, then settle
  task automatic drain(input int pause);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_char(out_ch.digit_char, out_ch.last_char, out_ch.bad_radix);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles, %0d characters still expected",
             quiet, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [rdsc_pkg::CFG_DATA_W-1:0] radix_data;
    logic [rdsc_pkg::IN_W-1:0]       value;
    logic [rdsc_pkg::RADIX_W-1:0]    r;
    int                              sent;
    int                              count;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: decimal, default alphabet
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd12345678901234567890);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    drain(SETTLE);

    // Binary: longest strings
    set_config(64'd2, rdsc_pkg::ALPHA_LO_RST, rdsc_pkg::ALPHA_HI_RST, 1'b0);
    send_value(64'd0);
    send_value(64'd1);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    drain(SETTLE);

    // Hex with extreme alphabets
    set_config(64'd16, '1, '0, 1'b0);
    send_value('1);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value(64'd7);
    drain(SETTLE);

    // Radix zero and one give the error result; upper data bits are ignored
    set_config(64'hFFFF_FFFF_FFFF_FFE0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_value(64'd5);
    send_value('1);
    drain(SETTLE);
    set_config(64'd1, rdsc_pkg::ALPHA_LO_RST, rdsc_pkg::ALPHA_HI_RST, 1'b0);
    send_value(64'd0);
    drain(SETTLE);

    // Radix above the maximum acts as sixteen
    set_config(64'd31, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    send_value(64'hFEDC_BA98_7654_3210);
    send_value(64'd15);
    drain(SETTLE);
    set_config(64'd17, rdsc_pkg::ALPHA_LO_RST, rdsc_pkg::ALPHA_HI_RST, 1'b0);
    send_value(64'd255);
    drain(SETTLE);

    // Small radix: unused alphabet bytes must never show up
    set_config(64'd3, rdsc_pkg::ALPHA_LO_RST, rdsc_pkg::ALPHA_HI_RST, 1'b0);
    send_value('1);
    send_value(64'd8);
    drain(SETTLE);

    // Random phases; the first one runs against a long output hold-off
    hold_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       r = rdsc_pkg::RADIX_W'($urandom_range(0, 1));
        1:       r = rdsc_pkg::RADIX_W'($urandom_range(17, 31));
        2:       r = 5'd2;
        3:       r = 5'd16;
        default: r = rdsc_pkg::RADIX_W'($urandom_range(3, 15));
      endcase
      radix_data = {$urandom, $urandom};
      radix_data[rdsc_pkg::RADIX_W-1:0] = r;
      set_config(radix_data, {$urandom, $urandom}, {$urandom, $urandom},
                 $urandom_range(0, 3) == 0);
      count = $urandom_range(6, 14);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      repeat (count) begin
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        case ($urandom_range(0, 7))
          0:       value = 64'd0;
          1:       value = 64'($urandom_range(1, 1000));
          2:       value = '1;
          3:       value = 64'd1 << $urandom_range(0, 63);
          4, 5:    value = {$urandom, $urandom} >> $urandom_range(0, 63);
          default: value = {$urandom, $urandom};
        endcase
        send_value(value);
        sent++;
      end
      drain(SETTLE);
    end

    drain(END_CYCLES);
    $display("Converted %0d values into %0d characters, %0d of them radix errors.",
             sb.values_in, sb.chars_out, sb.bad_out);
    $display("Radix settings used: %0d distinct; longest digit string: %0d characters.",
             $countones(sb.radix_used), sb.longest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
